/* rtl/quadratic_root_solver_unit_macros.svh */
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define QRS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qrs assertion failed");
`define QRS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qrs assertion failed");
`else
`define QRS_ASSERT_IMP(label, clk, rst, ante, cons)
`define QRS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/qrs_pkg.sv */
`timescale 1ns / 1ps
package qrs_pkg;
   localparam int COEF_WIDTH = 16;
   localparam int OUT_FRAC   = 16;
   localparam int RES_W      = 32;
   localparam int PROD_W     = 2 * COEF_WIDTH;
   localparam int DISC_W     = PROD_W + 2;
   localparam int ROOT_W     = DISC_W / 2;
   localparam int NUM_W      = ROOT_W + 1;
   localparam int DIVD_W     = NUM_W + OUT_FRAC;
   localparam int DIVS_W     = COEF_WIDTH + 1;
   localparam int MUL_CNT_W  = $clog2(COEF_WIDTH);
   localparam int SQRT_CNT_W = $clog2(ROOT_W);
   localparam int DIV_CNT_W  = $clog2(DIVD_W);

   typedef logic [COEF_WIDTH-1:0] mag_type;
   typedef logic [PROD_W-1:0]     prod_type;
   typedef logic [DISC_W-1:0]     disc_type;
   typedef logic [ROOT_W-1:0]     root_type;
   typedef logic [DIVD_W-1:0]     quo_type;
   typedef logic [DIVS_W-1:0]     dvs_type;

   localparam logic [1:0] CNT_COMPLEX  = 2'd0;
   localparam logic [1:0] CNT_DOUBLE   = 2'd1;
   localparam logic [1:0] CNT_DISTINCT = 2'd2;
endpackage

/* rtl/qrs_mul.sv */
`timescale 1ns / 1ps
module qrs_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  qrs_pkg::mag_type  mcand,
   input  qrs_pkg::mag_type  mplier,
   output logic              done,
   output qrs_pkg::prod_type product
);
   import qrs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   mag_type              mcand_ff, mcand_in;
   mag_type              hi_ff, hi_in;
   mag_type              lo_ff, lo_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [COEF_WIDTH:0]  sum;

   // shift-add, one multiplier bit per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      sum      = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         busy_in  = 1'b1;
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = mplier;
         cnt_in   = '0;
      end else if (busy_ff) begin
         hi_in  = sum[COEF_WIDTH:1];
         lo_in  = {sum[0], lo_ff[COEF_WIDTH-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(COEF_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      cnt_ff   <= cnt_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};
endmodule

/* rtl/qrs_isqrt.sv */
`timescale 1ns / 1ps
module qrs_isqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  qrs_pkg::disc_type radicand,
   output logic              done,
   output qrs_pkg::root_type root
);
   import qrs_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   disc_type              val_ff, val_in;
   logic [ROOT_W+1:0]     rem_ff, rem_in;
   root_type              root_ff, root_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ROOT_W+3:0]     rs;
   logic [ROOT_W+3:0]     trial;

   // one result bit per cycle, two radicand bits shifted in
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      rs      = {rem_ff, val_ff[DISC_W-1:DISC_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[DISC_W-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (rs >= trial) begin
            rem_in  = (ROOT_W + 2)'(rs - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rs[ROOT_W+1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == SQRT_CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

/* rtl/qrs_div.sv */
`timescale 1ns / 1ps
module qrs_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  qrs_pkg::quo_type dividend,
   input  qrs_pkg::dvs_type divisor,
   output logic             done,
   output qrs_pkg::quo_type quotient
);
   import qrs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   quo_type              quo_ff, quo_in;
   dvs_type              dvs_ff, dvs_in;
   dvs_type              rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVS_W:0]      rs;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      rs      = {rem_ff, quo_ff[DIVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         quo_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (rs >= {1'b0, dvs_ff}) begin
            rem_in = DIVS_W'(rs - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = rs[DIVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         if (cnt_ff == DIV_CNT_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/quadratic_root_solver_unit.sv */
// Quadratic root solver: takes signed Q8.8 coefficients a, b, c and returns both roots of
// a*x^2 + b*x + c as signed Q16.16 real and imaginary parts, with the real root count,
// a flag for a zero leading coefficient (roots then zero) and a flag for saturated roots.
// The discriminant is exact and its square root truncated; quotients truncate toward zero.
// One item is in work at a time: the bit-serial products b*b and a*c run in parallel, then
// the bit-serial square root, then the two restoring dividers in parallel (one quotient bit
// per cycle), with the handoff state S_DISC before the root and S_FIN after the dividers.
// With a zero leading coefficient the item goes straight from S_IDLE to S_FIN.
// A new item is taken while the previous result still waits in the rsp register.
`timescale 1ns / 1ps
`include "quadratic_root_solver_unit_macros.svh"
module quadratic_root_solver_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [qrs_pkg::COEF_WIDTH-1:0] req_coef_quad,
   input  logic signed [qrs_pkg::COEF_WIDTH-1:0] req_coef_lin,
   input  logic signed [qrs_pkg::COEF_WIDTH-1:0] req_coef_const,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic        [1:0]                  rsp_real_root_count,
   output logic signed [qrs_pkg::RES_W-1:0]   rsp_first_real,
   output logic signed [qrs_pkg::RES_W-1:0]   rsp_first_imag,
   output logic signed [qrs_pkg::RES_W-1:0]   rsp_second_real,
   output logic signed [qrs_pkg::RES_W-1:0]   rsp_second_imag,
   output logic                               rsp_zero_leading,
   output logic                               rsp_saturated
);
   import qrs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DISC,
      S_ROOT,
      S_DIV,
      S_FIN
   } state_type;

   localparam quo_type POS_LIM = quo_type'({1'b0, {(RES_W - 1){1'b1}}});
   localparam quo_type NEG_LIM = quo_type'({1'b1, {(RES_W - 1){1'b0}}});

   // saturate and sign a quotient magnitude, {sat, value}
   function automatic logic [RES_W:0] finish(input quo_type q, input logic neg);
      quo_type         nq;
      logic [RES_W:0]  r;
      nq = ~q + 1'b1;
      if (!neg || q == '0) begin
         if (q > POS_LIM) r = {1'b1, POS_LIM[RES_W-1:0]};
         else r = {1'b0, q[RES_W-1:0]};
      end else begin
         if (q > NEG_LIM) r = {1'b1, NEG_LIM[RES_W-1:0]};
         else r = {1'b0, nq[RES_W-1:0]};
      end
      return r;
   endfunction

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mag_type           am_ff, am_in, bm_ff, bm_in;
   logic              an_ff, an_in, bn_ff, bn_in, same_ff, same_in;
   logic              zl_ff, zl_in;
   logic [DISC_W:0]   d_ff, d_in;
   logic              real_ff, real_in;
   logic              n1neg_ff, n1neg_in, n2neg_ff, n2neg_in;
   logic [1:0]        count_ff, count_in;
   logic [1:0]        out_count_ff, out_count_in;
   logic [RES_W-1:0]  fr_ff, fr_in, fi_ff, fi_in, sr_ff, sr_in, si_ff, si_in;
   logic              out_zl_ff, out_zl_in, out_sat_ff, out_sat_in;

   logic              accept;
   logic              an_c, bn_c, cn_c;
   mag_type           am_c, bm_c, cm_c;
   logic              mul_start, mul_done, mul_ac_done;
   prod_type          sq, pr;
   disc_type          p4;
   disc_type          dmag;
   logic              sqrt_start, sqrt_done;
   root_type          s;
   logic [NUM_W:0]    nb, sx, n1, n2;
   logic [NUM_W-1:0]  n1mag, n2mag;
   logic              div_start, div_done, div_second_done;
   quo_type           q1, q2;
   logic [RES_W:0]    f1, f2, f3;

   assign accept = req_valid && req_ready;
   assign an_c   = req_coef_quad[COEF_WIDTH-1];
   assign bn_c   = req_coef_lin[COEF_WIDTH-1];
   assign cn_c   = req_coef_const[COEF_WIDTH-1];
   assign am_c   = an_c ? mag_type'(-req_coef_quad) : mag_type'(req_coef_quad);
   assign bm_c   = bn_c ? mag_type'(-req_coef_lin) : mag_type'(req_coef_lin);
   assign cm_c   = cn_c ? mag_type'(-req_coef_const) : mag_type'(req_coef_const);

   assign mul_start  = accept && (am_c != '0);
   assign sqrt_start = (state_ff == S_DISC);
   assign div_start  = (state_ff == S_ROOT) && sqrt_done;

   qrs_mul u_mul_bb (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (bm_c),
      .mplier  (bm_c),
      .done    (mul_done),
      .product (sq)
   );

   qrs_mul u_mul_ac (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (am_c),
      .mplier  (cm_c),
      .done    (mul_ac_done),
      .product (pr)
   );

   assign p4   = {pr, 2'b00};
   assign dmag = d_ff[DISC_W] ? DISC_W'(~d_ff + 1'b1) : d_ff[DISC_W-1:0];

   qrs_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (dmag),
      .done     (sqrt_done),
      .root     (s)
   );

   // numerators: -b - s and -b + s, or -b and s for a complex pair
   assign nb    = bn_ff ? {3'b000, bm_ff} : ~{3'b000, bm_ff} + 1'b1;
   assign sx    = {2'b00, s};
   assign n1    = real_ff ? nb - sx : nb;
   assign n2    = real_ff ? nb + sx : sx;
   assign n1mag = n1[NUM_W] ? NUM_W'(~n1 + 1'b1) : n1[NUM_W-1:0];
   assign n2mag = n2[NUM_W] ? NUM_W'(~n2 + 1'b1) : n2[NUM_W-1:0];

   qrs_div u_div_first (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({n1mag, {OUT_FRAC{1'b0}}}),
      .divisor  ({am_ff, 1'b0}),
      .done     (div_done),
      .quotient (q1)
   );

   qrs_div u_div_second (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({n2mag, {OUT_FRAC{1'b0}}}),
      .divisor  ({am_ff, 1'b0}),
      .done     (div_second_done),
      .quotient (q2)
   );

   assign f1 = finish(q1, n1neg_ff ^ an_ff);
   assign f2 = finish(q2, n2neg_ff ^ an_ff);
   assign f3 = finish(q2, ~an_ff);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      am_in        = am_ff;
      bm_in        = bm_ff;
      an_in        = an_ff;
      bn_in        = bn_ff;
      same_in      = same_ff;
      zl_in        = zl_ff;
      d_in         = d_ff;
      real_in      = real_ff;
      count_in     = count_ff;
      n1neg_in     = n1neg_ff;
      n2neg_in     = n2neg_ff;
      out_count_in = out_count_ff;
      fr_in        = fr_ff;
      fi_in        = fi_ff;
      sr_in        = sr_ff;
      si_in        = si_ff;
      out_zl_in    = out_zl_ff;
      out_sat_in   = out_sat_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               am_in   = am_c;
               bm_in   = bm_c;
               an_in   = an_c;
               bn_in   = bn_c;
               same_in = (an_c == cn_c);
               zl_in   = (am_c == '0);
               state_in = (am_c == '0) ? S_FIN : S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done && mul_ac_done) begin
               if (same_ff) d_in = {3'b000, sq} - {1'b0, p4};
               else d_in = {3'b000, sq} + {1'b0, p4};
               state_in = S_DISC;
            end
         end
         S_DISC: begin
            real_in = ~d_ff[DISC_W];
            if (d_ff[DISC_W]) count_in = CNT_COMPLEX;
            else if (d_ff == '0) count_in = CNT_DOUBLE;
            else count_in = CNT_DISTINCT;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (sqrt_done) begin
               n1neg_in = n1[NUM_W];
               n2neg_in = n2[NUM_W];
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done && div_second_done) state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               out_zl_in    = zl_ff;
               if (zl_ff) begin
                  out_count_in = CNT_COMPLEX;
                  fr_in        = '0;
                  fi_in        = '0;
                  sr_in        = '0;
                  si_in        = '0;
                  out_sat_in   = 1'b0;
               end else if (real_ff) begin
                  out_count_in = count_ff;
                  fr_in        = f1[RES_W-1:0];
                  fi_in        = '0;
                  sr_in        = f2[RES_W-1:0];
                  si_in        = '0;
                  out_sat_in   = f1[RES_W] | f2[RES_W];
               end else begin
                  out_count_in = count_ff;
                  fr_in        = f1[RES_W-1:0];
                  fi_in        = f3[RES_W-1:0];
                  sr_in        = f1[RES_W-1:0];
                  si_in        = f2[RES_W-1:0];
                  out_sat_in   = f1[RES_W] | f2[RES_W] | f3[RES_W];
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      am_ff        <= am_in;
      bm_ff        <= bm_in;
      an_ff        <= an_in;
      bn_ff        <= bn_in;
      same_ff      <= same_in;
      zl_ff        <= zl_in;
      d_ff         <= d_in;
      real_ff      <= real_in;
      count_ff     <= count_in;
      n1neg_ff     <= n1neg_in;
      n2neg_ff     <= n2neg_in;
      out_count_ff <= out_count_in;
      fr_ff        <= fr_in;
      fi_ff        <= fi_in;
      sr_ff        <= sr_in;
      si_ff        <= si_in;
      out_zl_ff    <= out_zl_in;
      out_sat_ff   <= out_sat_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_real_root_count = out_count_ff;
   assign rsp_first_real      = fr_ff;
   assign rsp_first_imag      = fi_ff;
   assign rsp_second_real     = sr_ff;
   assign rsp_second_imag     = si_ff;
   assign rsp_zero_leading    = out_zl_ff;
   assign rsp_saturated       = out_sat_ff;

   `QRS_ASSERT_NXT(a_one_in_work, clock, reset, accept, !req_ready)
   `QRS_ASSERT_IMP(a_zero_lead_clear, clock, reset, rsp_valid && rsp_zero_leading,
      rsp_real_root_count == CNT_COMPLEX && !rsp_saturated && rsp_first_real == '0)
   `QRS_ASSERT_IMP(a_real_no_imag, clock, reset, rsp_valid && rsp_real_root_count != CNT_COMPLEX,
      rsp_first_imag == '0 && rsp_second_imag == '0)
   `QRS_ASSERT_IMP(a_pair_same_real, clock, reset,
      rsp_valid && rsp_real_root_count == CNT_COMPLEX && !rsp_zero_leading,
      rsp_first_real == rsp_second_real)
   `QRS_ASSERT_IMP(a_count_code, clock, reset, rsp_valid,
      rsp_real_root_count == CNT_COMPLEX || rsp_real_root_count == CNT_DOUBLE ||
      rsp_real_root_count == CNT_DISTINCT)
endmodule

/* verif/tb_quadratic_root_solver_unit.sv */
`timescale 1ns / 1ps
module tb_quadratic_root_solver_unit;
   localparam int CW          = qrs_pkg::COEF_WIDTH;
   localparam int RW          = qrs_pkg::RES_W;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 144;
   localparam int DIR_ITEMS   = 20;
   localparam int DRAIN       = 150;

   typedef logic signed [CW-1:0] coef_type;
   typedef logic signed [RW-1:0] part_type;

   typedef struct {
      coef_type   a;
      coef_type   b;
      coef_type   c;
      logic [1:0] real_root_count;
      part_type   first_real;
      part_type   first_imag;
      part_type   second_real;
      part_type   second_imag;
      logic       zero_leading;
      logic       saturated;
   } root_set_type;

   class root_checker;
      root_set_type expected_roots[$];
      int           mismatches = 0;
      bit           clipped;

      function longint floor_sqrt(longint v);
         longint rem;
         longint root;
         longint trial;
         rem  = 0;
         root = 0;
         for (int i = 31; i >= 0; i--) begin
            rem   = (rem << 2) | ((v >> (2 * i)) & 3);
            trial = (root << 2) | 1;
            if (rem >= trial) begin
               rem  = rem - trial;
               root = (root << 1) | 1;
            end else begin
               root = root << 1;
            end
         end
         return root;
      endfunction

      // (num << 16) / (2a), truncated toward zero, clipped to 32 bits
      function part_type scaled_quotient(longint num, longint aq);
         longint nmag;
         longint amag;
         longint q;
         bit     neg;
         nmag = (num < 0) ? -num : num;
         amag = (aq < 0) ? -aq : aq;
         q    = (nmag << 16) / (2 * amag);
         neg  = ((num < 0) != (aq < 0)) && (q != 0);
         if (!neg) begin
            if (q > 64'sd2147483647) begin
               clipped = 1'b1;
               q       = 64'sd2147483647;
            end
            return part_type'(q);
         end
         if (q > 64'sd2147483648) begin
            clipped = 1'b1;
            q       = 64'sd2147483648;
         end
         return part_type'(-q);
      endfunction

      function root_set_type solve_quadratic(coef_type a, coef_type b, coef_type c);
         root_set_type r;
         longint       aq;
         longint       bq;
         longint       cq;
         longint       disc;
         longint       s;
         aq = a;
         bq = b;
         cq = c;
         r.a               = a;
         r.b               = b;
         r.c               = c;
         r.real_root_count = qrs_pkg::CNT_COMPLEX;
         r.first_real      = '0;
         r.first_imag      = '0;
         r.second_real     = '0;
         r.second_imag     = '0;
         r.zero_leading    = 1'b0;
         r.saturated       = 1'b0;
         if (aq == 0) begin
            r.zero_leading = 1'b1;
            return r;
         end
         clipped = 1'b0;
         disc    = bq * bq - 4 * aq * cq;
         s       = floor_sqrt((disc < 0) ? -disc : disc);
         if (disc >= 0) begin
            r.real_root_count = (disc > 0) ? qrs_pkg::CNT_DISTINCT : qrs_pkg::CNT_DOUBLE;
            r.first_real      = scaled_quotient(-bq - s, aq);
            r.second_real     = scaled_quotient(-bq + s, aq);
         end else begin
            r.real_root_count = qrs_pkg::CNT_COMPLEX;
            r.first_real      = scaled_quotient(-bq, aq);
            r.second_real     = r.first_real;
            r.first_imag      = scaled_quotient(-s, aq);
            r.second_imag     = scaled_quotient(s, aq);
         end
         r.saturated = clipped;
         return r;
      endfunction

      function void note_coefficients(coef_type a, coef_type b, coef_type c);
         expected_roots.push_back(solve_quadratic(a, b, c));
      endfunction

      task report_mismatch(string what, longint got, longint want, root_set_type e);
         $display("mismatch %s: got %0d expected %0d for a=%0d b=%0d c=%0d",
                  what, got, want, e.a, e.b, e.c);
         mismatches++;
      endtask

      task check_roots(logic [1:0] cnt, part_type fr, part_type fi, part_type sr,
                       part_type si, logic zl, logic sat);
         root_set_type e;
         if (expected_roots.size() == 0) begin
            report_mismatch("unexpected rsp transfer", 1, 0, e);
            return;
         end
         e = expected_roots.pop_front();
         if (cnt !== e.real_root_count) report_mismatch("real_root_count", cnt,
                                                        e.real_root_count, e);
         if (fr !== e.first_real)   report_mismatch("first_real", fr, e.first_real, e);
         if (fi !== e.first_imag)   report_mismatch("first_imag", fi, e.first_imag, e);
         if (sr !== e.second_real)  report_mismatch("second_real", sr, e.second_real, e);
         if (si !== e.second_imag)  report_mismatch("second_imag", si, e.second_imag, e);
         if (zl !== e.zero_leading) report_mismatch("zero_leading", zl, e.zero_leading, e);
         if (sat !== e.saturated)   report_mismatch("saturated", sat, e.saturated, e);
      endtask
   endclass

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   coef_type req_coef_quad = '0;
   coef_type req_coef_lin = '0;
   coef_type req_coef_const = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   logic [1:0] rsp_real_root_count;
   part_type rsp_first_real;
   part_type rsp_first_imag;
   part_type rsp_second_real;
   part_type rsp_second_imag;
   logic     rsp_zero_leading;
   logic     rsp_saturated;

   root_checker board;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   quadratic_root_solver_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_coef_quad       (req_coef_quad),
      .req_coef_lin        (req_coef_lin),
      .req_coef_const      (req_coef_const),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_real_root_count (rsp_real_root_count),
      .rsp_first_real      (rsp_first_real),
      .rsp_first_imag      (rsp_first_imag),
      .rsp_second_real     (rsp_second_real),
      .rsp_second_imag     (rsp_second_imag),
      .rsp_zero_leading    (rsp_zero_leading),
      .rsp_saturated       (rsp_saturated)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            board.check_roots(rsp_real_root_count, rsp_first_real, rsp_first_imag,
                              rsp_second_real, rsp_second_imag, rsp_zero_leading,
                              rsp_saturated);
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic coef_type corner_value();
      case ($urandom_range(5))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return -16'sd1;
         3: return 16'sd1;
         4: return 16'sd0;
         default: return coef_type'($urandom);
      endcase
   endfunction

   // holds valid until the transfer; valid stays high when no gap follows
   task automatic send_item(coef_type a, coef_type b, coef_type c);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_coef_quad  <= a;
      req_coef_lin   <= b;
      req_coef_const <= c;
      do @(posedge clock); while (!req_ready);
      board.note_coefficients(a, b, c);
   endtask

   initial begin
      coef_type dir_a [DIR_ITEMS];
      coef_type dir_b [DIR_ITEMS];
      coef_type dir_c [DIR_ITEMS];
      int       phase_send [4];
      int       phase_recv [4];
      coef_type a;
      coef_type b;
      coef_type c;
      int       m;
      int       r;

      dir_a = '{
         16'sd0, 16'sd0, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
         16'sd1, -16'sd1, 16'sd256, -16'sd256, 16'sd256, 16'sd256,
         16'sd256, -16'sd1, 16'sd1, 16'sd1, -16'sd1, 16'sd1, 16'sd0, -16'sd1};
      dir_b = '{
         -16'sd32768, 16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
         -16'sd32768, -16'sd32768, 16'sd512, 16'sd512, 16'sd0, 16'sd0,
         -16'sd768, 16'sd0, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd0,
         16'sd32767, 16'sd32767};
      dir_c = '{
         16'sd32767, 16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
         16'sd0, 16'sd0, 16'sd256, -16'sd256, 16'sd0, 16'sd256,
         16'sd512, 16'sd1, -16'sd32768, -16'sd32767, 16'sd32767, 16'sd32767,
         -16'sd32768, -16'sd32768};
      phase_send = '{0, 56, 0, 13};
      phase_recv = '{0, 0, 56, 13};

      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ITEMS; i++) send_item(dir_a[i], dir_b[i], dir_c[i]);

      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct  = phase_send[p % 4];
         recv_stall_pct = phase_recv[p % 4];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(9))
               0, 1, 2, 3: begin
                  a = coef_type'($urandom);
                  b = coef_type'($urandom);
                  c = coef_type'($urandom);
               end
               4, 5: begin
                  a = coef_type'(int'($urandom_range(2048)) - 1024);
                  b = coef_type'(int'($urandom_range(2048)) - 1024);
                  c = coef_type'(int'($urandom_range(2048)) - 1024);
               end
               6: begin
                  a = '0;
                  b = coef_type'($urandom);
                  c = coef_type'($urandom);
               end
               7: begin
                  // double root: b = 2ar, c = ar^2
                  m = int'($urandom_range(200)) - 100;
                  if (m == 0) m = 1;
                  r = int'($urandom_range(20)) - 10;
                  a = coef_type'(m);
                  b = coef_type'(2 * m * r);
                  c = coef_type'(m * r * r);
               end
               default: begin
                  a = $urandom_range(1) ? corner_value() : coef_type'($urandom);
                  b = $urandom_range(1) ? corner_value() : coef_type'($urandom);
                  c = $urandom_range(1) ? corner_value() : coef_type'($urandom);
               end
            endcase
            send_item(a, b, c);
         end
      end
      req_valid <= 1'b0;

      while (board.expected_roots.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (board.expected_roots.size() != 0) begin
         board.report_mismatch("results left over", board.expected_roots.size(), 0,
                               board.expected_roots[0]);
      end
      if (board.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl
rtl/qrs_pkg.sv
rtl/qrs_mul.sv
rtl/qrs_isqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver_unit.sv
verif/tb_quadratic_root_solver_unit.sv
